@@ rtl/tau_pkg.sv @@
// ============================================================================
// tau_pkg: shared types and constants for the triangle area unit
// Holds the field widths, sine phase constants, polynomial coefficients and
// the control word that travels with each transaction through the pipeline.
// ============================================================================
package tau_pkg;

    // Default geometry of the side operands.
    localparam int SIDE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF = 4;

    // Fixed field widths.
    localparam int ANGLE_W = 20;
    localparam int AREA_W  = 29;
    localparam int OUT_W   = ((AREA_W + 7) / 8) * 8;

    // Largest area magnitude that can be reported.
    localparam logic [AREA_W-2:0] AREA_MAX = {(AREA_W-1){1'b1}};

    // One in Q30.
    localparam logic [30:0] Q30_ONE = 31'd1073741824;

    // Phase scale factors (2^-32 turn per output LSB after the >> 32).
    localparam logic [45:0] K_RAD = 46'd44798133900177;
    localparam logic [45:0] K_DEG = 46'd50039995859672;
    localparam int K_SPLIT = 23;
    localparam logic [K_SPLIT-1:0] K_RAD_LO = K_RAD[K_SPLIT-1:0];
    localparam logic [K_SPLIT-1:0] K_RAD_HI = K_RAD[45:K_SPLIT];
    localparam logic [K_SPLIT-1:0] K_DEG_LO = K_DEG[K_SPLIT-1:0];
    localparam logic [K_SPLIT-1:0] K_DEG_HI = K_DEG[45:K_SPLIT];

    // Quarter-wave sine polynomial, lowest order first, Q30.
    localparam int NUM_COEF = 6;
    localparam logic [30:0] SINE_COEF [NUM_COEF] = '{
        31'd1686629713, 31'd693598668, 31'd85569306,
        31'd5026995,    31'd172272,    31'd3864
    };

    // Latency of the side-angle-side datapath in cycles.
    localparam int SAS_LAT = 12;

    // Function select codes.
    localparam logic FUNC_HERON = 1'b0;
    localparam logic FUNC_SAS   = 1'b1;

    // Control word carried beside the datapaths.
    typedef struct packed {
        logic valid;
        logic func;
    } ctrl_t;

endpackage

@@ rtl/tau_delay.sv @@
// ============================================================================
// tau_delay: enable-driven delay line
// Shifts a word through DEPTH registers whenever the pipeline advances.
// ============================================================================
module tau_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    // Shift one place on every advance.
    always_ff @(posedge aclk) begin
        if (en) begin
            tap_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++) begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

@@ rtl/tau_heron.sv @@
// ============================================================================
// tau_heron: pipelined Heron area datapath
// Forms p*q1*q2*q3 exactly, takes its integer square root one result bit per
// stage and scales the root down to the Q.FRAC_BITS area.
// ============================================================================
module tau_heron #(
    parameter int SIDE_BITS = tau_pkg::SIDE_BITS_DEF,
    parameter int FRAC_BITS = tau_pkg::FRAC_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [SIDE_BITS-1:0]        side_a,
    input  logic [SIDE_BITS-1:0]        side_b,
    input  logic [SIDE_BITS-1:0]        side_c,
    output logic [tau_pkg::AREA_W-1:0]  area,
    output logic                        bad_triangle
);

    localparam int SW   = SIDE_BITS;
    localparam int S1W  = SW + 1;
    localparam int PW   = SW + 2;
    localparam int PQW  = PW + S1W;
    localparam int QQW  = 2 * S1W;
    localparam int HW   = S1W;
    localparam int PPW  = PQW + HW;
    localparam int XWE  = 4 * SW + 6;
    localparam int RW   = XWE / 2;
    localparam int REMW = RW + 2;
    localparam int LAT  = RW + 5;

    // Stage 1: sums, differences and the validity check.
    logic [PW-1:0]  p_reg;
    logic [S1W-1:0] q1_reg, q2_reg, q3_reg;
    logic [S1W-1:0] bc, ac, ab;
    logic           bad_next;

    always_comb begin
        bc = S1W'(side_b) + S1W'(side_c);
        ac = S1W'(side_a) + S1W'(side_c);
        ab = S1W'(side_a) + S1W'(side_b);
        bad_next = (side_a == '0) || (side_b == '0) || (side_c == '0) ||
                   (bc <= S1W'(side_a)) || (ac <= S1W'(side_b)) ||
                   (ab <= S1W'(side_c));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg  <= PW'(side_a) + PW'(side_b) + PW'(side_c);
            q1_reg <= bc - S1W'(side_a);
            q2_reg <= ac - S1W'(side_b);
            q3_reg <= ab - S1W'(side_c);
        end
    end

    // Stage 2: two pair products.
    logic [PQW-1:0] pq_reg;
    logic [QQW-1:0] qq_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            pq_reg <= PQW'(p_reg) * PQW'(q1_reg);
            qq_reg <= QQW'(q2_reg) * QQW'(q3_reg);
        end
    end

    // Stage 3: the wide product split into two partial products.
    logic [PPW-1:0] pp_lo_reg, pp_hi_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            pp_lo_reg <= PPW'(pq_reg) * PPW'(qq_reg[HW-1:0]);
            pp_hi_reg <= PPW'(pq_reg) * PPW'(qq_reg[QQW-1:HW]);
        end
    end

    // Stage 4 and the root stages: radicand, partial remainder and root.
    logic [XWE-1:0]  x_reg    [RW+1];
    logic [REMW-1:0] rem_reg  [RW+1];
    logic [RW-1:0]   root_reg [RW+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]    <= XWE'(pp_lo_reg) + (XWE'(pp_hi_reg) << HW);
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
        end
    end

    // One result bit per stage, restoring method on two radicand bits.
    for (genvar i = 1; i <= RW; i++) begin : g_root
        logic [REMW-1:0] rem2;
        logic [REMW-1:0] trial;
        logic            fits;

        always_comb begin
            rem2  = {rem_reg[i-1][REMW-3:0], x_reg[i-1][XWE-1 -: 2]};
            trial = {root_reg[i-1], 2'b01};
            fits  = (rem2 >= trial);
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[i]    <= x_reg[i-1] << 2;
                rem_reg[i]  <= fits ? rem2 - trial : rem2;
                root_reg[i] <= {root_reg[i-1][RW-2:0], fits};
            end
        end
    end

    // The error flag rides beside the datapath up to the last stage.
    logic bad_tap;

    tau_delay #(
        .WIDTH (1),
        .DEPTH (LAT - 1)
    ) u_bad_dly (
        .aclk (aclk),
        .en   (en),
        .din  (bad_next),
        .dout (bad_tap)
    );

    // Final stage: scale, saturate and force zero on error.
    logic [RW-1:0]              root_sh;
    logic [tau_pkg::AREA_W-1:0] area_reg;
    logic                       bad_reg;

    assign root_sh = root_reg[RW] >> (FRAC_BITS + 2);

    always_ff @(posedge aclk) begin
        if (en) begin
            bad_reg <= bad_tap;
            if (bad_tap) begin
                area_reg <= '0;
            end else if (64'(root_sh) > 64'(tau_pkg::AREA_MAX)) begin
                area_reg <= tau_pkg::AREA_W'(tau_pkg::AREA_MAX);
            end else begin
                area_reg <= tau_pkg::AREA_W'(root_sh);
            end
        end
    end

    assign area         = area_reg;
    assign bad_triangle = bad_reg;

endmodule

@@ rtl/tau_sas.sv @@
// ============================================================================
// tau_sas: pipelined side-angle-side area datapath
// Converts the angle to a 2^-32 turn phase, evaluates the quarter-wave sine
// polynomial one Horner step per stage, and scales 0.5*a*b*sin to Q.FRAC_BITS.
// ============================================================================
module tau_sas #(
    parameter int SIDE_BITS = tau_pkg::SIDE_BITS_DEF,
    parameter int FRAC_BITS = tau_pkg::FRAC_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               en,
    input  logic [SIDE_BITS-1:0]               side_a,
    input  logic [SIDE_BITS-1:0]               side_b,
    input  logic signed [tau_pkg::ANGLE_W-1:0] angle,
    input  logic                               in_radians,
    output logic [tau_pkg::AREA_W-1:0]         area
);

    localparam int ABW  = 2 * SIDE_BITS;
    localparam int PRW  = ABW + 31;
    localparam int AKW  = tau_pkg::ANGLE_W + tau_pkg::K_SPLIT + 1;
    localparam int NH   = tau_pkg::NUM_COEF - 1;
    localparam int SHR  = 31 + FRAC_BITS;

    // Stage 1: angle times the two halves of the scale factor, and a*b.
    logic signed [AKW-1:0]      akl_reg, akh_reg;
    logic [tau_pkg::K_SPLIT-1:0] k_lo, k_hi;
    logic [ABW-1:0]              ab_sr [1:10];

    assign k_lo = in_radians ? tau_pkg::K_RAD_LO : tau_pkg::K_DEG_LO;
    assign k_hi = in_radians ? tau_pkg::K_RAD_HI : tau_pkg::K_DEG_HI;

    always_ff @(posedge aclk) begin
        if (en) begin
            akl_reg  <= angle * $signed({1'b0, k_lo});
            akh_reg  <= angle * $signed({1'b0, k_hi});
            ab_sr[1] <= ABW'(side_a) * ABW'(side_b);
            for (int i = 2; i <= 10; i++) begin
                ab_sr[i] <= ab_sr[i-1];
            end
        end
    end

    // Stage 2: rounded phase, bits 63..32 of the combined product.
    logic signed [63:0] phase_full;
    logic [31:0]        phase_reg;

    assign phase_full = (64'(akh_reg) <<< tau_pkg::K_SPLIT) + 64'(akl_reg) +
                        64'sh80000000;

    always_ff @(posedge aclk) begin
        if (en) begin
            phase_reg <= phase_full[63:32];
        end
    end

    // Stage 3: fold the phase into the first quadrant.
    logic [30:0] z_reg;
    logic        neg_sr [3:11];

    always_ff @(posedge aclk) begin
        if (en) begin
            z_reg <= phase_reg[30] ? tau_pkg::Q30_ONE - 31'(phase_reg[29:0])
                                   : 31'(phase_reg[29:0]);
            neg_sr[3] <= phase_reg[31];
            for (int i = 4; i <= 11; i++) begin
                neg_sr[i] <= neg_sr[i-1];
            end
        end
    end

    // Stage 4: z squared.
    logic [61:0] zz;
    logic [30:0] z2_sr [NH];
    logic [30:0] z_sr  [NH+1];

    assign zz = 62'(z_reg) * 62'(z_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            z2_sr[0] <= zz[60:30];
            z_sr[0]  <= z_reg;
        end
    end

    // Horner stages, highest coefficient first.
    logic [30:0] t_reg [NH];

    for (genvar i = 0; i < NH; i++) begin : g_horner
        logic [30:0] t_in;
        logic [61:0] tz;

        assign t_in = (i == 0) ? tau_pkg::SINE_COEF[NH] : t_reg[(i == 0) ? 0 : i-1];
        assign tz   = 62'(t_in) * 62'(z2_sr[i]);

        always_ff @(posedge aclk) begin
            if (en) begin
                t_reg[i]  <= tau_pkg::SINE_COEF[NH-1-i] - tz[60:30];
                z_sr[i+1] <= z_sr[i];
            end
        end

        // Pass z squared on to the next Horner step.
        if (i < NH - 1) begin : g_z2
            always_ff @(posedge aclk) begin
                if (en) begin
                    z2_sr[i+1] <= z2_sr[i];
                end
            end
        end
    end

    // Stage 10: final multiply by z.
    logic [61:0] tzf;
    logic [31:0] sine_reg;

    assign tzf = 62'(t_reg[NH-1]) * 62'(z_sr[NH]);

    always_ff @(posedge aclk) begin
        if (en) begin
            sine_reg <= tzf[61:30];
        end
    end

    // Stage 11: cap the sine at one and multiply by a*b.
    logic [30:0]    sine_cap;
    logic [PRW-1:0] prod_reg;

    assign sine_cap = (sine_reg > 32'(tau_pkg::Q30_ONE)) ? tau_pkg::Q30_ONE
                                                         : sine_reg[30:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= PRW'(ab_sr[10]) * PRW'(sine_cap);
        end
    end

    // Stage 12: scale, saturate and apply the sign.
    logic [PRW-1:0]             mag_full;
    logic [tau_pkg::AREA_W-1:0] mag;
    logic [tau_pkg::AREA_W-1:0] area_reg;

    always_comb begin
        mag_full = prod_reg >> SHR;
        if (mag_full > PRW'(tau_pkg::AREA_MAX)) begin
            mag = tau_pkg::AREA_W'(tau_pkg::AREA_MAX);
        end else begin
            mag = mag_full[tau_pkg::AREA_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            area_reg <= neg_sr[11] ? (~mag + 1'b1) : mag;
        end
    end

    assign area = area_reg;

endmodule

@@ rtl/triangle_area_unit.sv @@
// ============================================================================
// triangle_area_unit: pipelined fixed-point triangle area
// Top level: stream ports, control pipeline and result selection.
// ============================================================================
// Usage:
//   Input transactions arrive on the s_ channel: s_tdata carries the three
//   sides and the angle, s_tuser carries the function select and the angle
//   unit. Each input transaction yields exactly one result transaction on the
//   m_ channel: m_tdata carries the signed area, m_tuser the error flag.
//   func 0 computes Heron's formula, func 1 computes 0.5*a*b*sin(angle).
//   Throughput is one transaction per cycle while the receiver takes results.
//   The latency is set by the square root, which resolves one result bit per
//   pipeline stage; the sine path is padded to match.
//   Every stage advances together whenever the output register is empty or
//   being taken, so s_tready follows m_tready combinationally. When the
//   receiver stalls, the whole pipeline holds its contents and nothing is
//   dropped or repeated. Reset clears all valid bits; the datapath registers
//   keep whatever they hold and are ignored until refilled.
// ============================================================================
module triangle_area_unit #(
    parameter int SIDE_BITS = tau_pkg::SIDE_BITS_DEF,
    parameter int FRAC_BITS = tau_pkg::FRAC_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,

    // s_tdata: side_a, side_b, side_c, angle (lowest bit up), zero fill.
    // s_tuser: func, in_radians (lowest bit up).
    input  logic                                                  s_tvalid,
    output logic                                                  s_tready,
    input  logic [((3*SIDE_BITS+tau_pkg::ANGLE_W+7)/8)*8-1:0]     s_tdata,
    input  logic [1:0]                                            s_tuser,

    // m_tdata: area, zero fill. m_tuser: bad_triangle.
    output logic                                                  m_tvalid,
    input  logic                                                  m_tready,
    output logic [tau_pkg::OUT_W-1:0]                             m_tdata,
    output logic                                                  m_tuser
);

    localparam int SW    = SIDE_BITS;
    localparam int LAT   = 2 * SW + 8;
    localparam int A_LO  = 3 * SW;

    // Unpack the input transaction.
    logic                               func;
    logic                               in_radians;
    logic [SW-1:0]                      side_a, side_b, side_c;
    logic signed [tau_pkg::ANGLE_W-1:0] angle;

    assign func       = s_tuser[0];
    assign in_radians = s_tuser[1];
    assign side_a     = s_tdata[SW-1:0];
    assign side_b     = s_tdata[2*SW-1:SW];
    assign side_c     = s_tdata[3*SW-1:2*SW];
    assign angle      = $signed(s_tdata[A_LO+tau_pkg::ANGLE_W-1:A_LO]);

    // Global advance: the output register is empty or being taken.
    logic en;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // Control pipeline carrying valid and function select.
    tau_pkg::ctrl_t ctrl_reg [LAT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LAT; i++) begin
                ctrl_reg[i] <= '0;
            end
        end else if (en) begin
            ctrl_reg[0] <= '{valid: s_tvalid, func: func};
            for (int i = 1; i < LAT; i++) begin
                ctrl_reg[i] <= ctrl_reg[i-1];
            end
        end
    end

    // Heron datapath.
    logic [tau_pkg::AREA_W-1:0] heron_area;
    logic                       heron_bad;

    tau_heron #(
        .SIDE_BITS (SIDE_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_heron (
        .aclk         (aclk),
        .en           (en),
        .side_a       (side_a),
        .side_b       (side_b),
        .side_c       (side_c),
        .area         (heron_area),
        .bad_triangle (heron_bad)
    );

    // Side-angle-side datapath, padded to the Heron latency.
    logic [tau_pkg::AREA_W-1:0] sas_area;
    logic [tau_pkg::AREA_W-1:0] sas_area_dly;

    tau_sas #(
        .SIDE_BITS (SIDE_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_sas (
        .aclk       (aclk),
        .en         (en),
        .side_a     (side_a),
        .side_b     (side_b),
        .angle      (angle),
        .in_radians (in_radians),
        .area       (sas_area)
    );

    tau_delay #(
        .WIDTH (tau_pkg::AREA_W),
        .DEPTH (LAT - tau_pkg::SAS_LAT)
    ) u_sas_pad (
        .aclk (aclk),
        .en   (en),
        .din  (sas_area),
        .dout (sas_area_dly)
    );

    // Result selection from the final registers.
    logic out_sas;

    assign out_sas  = (ctrl_reg[LAT-1].func == tau_pkg::FUNC_SAS);
    assign m_tvalid = ctrl_reg[LAT-1].valid;
    assign m_tdata  = tau_pkg::OUT_W'(out_sas ? sas_area_dly : heron_area);
    assign m_tuser  = out_sas ? 1'b0 : heron_bad;

    // An error result always reports a zero area.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[tau_pkg::AREA_W-1:0] == '0)
        else $error("error result with nonzero area");

    // A Heron area is never negative.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !out_sas |-> !m_tdata[tau_pkg::AREA_W-1])
        else $error("negative Heron area");

    // Reset empties the pipeline.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A held result stays in place while the receiver stalls.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule
